/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the confusion counter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSCC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TSCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSCC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hw/rtl/tscc_pkg.sv */
// Shared types and constants of the threshold sweep confusion counter
package tscc_pkg;

  localparam int MODE_W     = 2;
  localparam int SCORE_W    = 32;
  localparam int NTHR_W     = 7;
  localparam int RANGE_W    = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int ROW_W      = 6;
  localparam int OUT_CNT_W  = 32;

  localparam logic [MODE_W-1:0] MODE_ACC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_THRESHOLDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RANGE    = 1'b1;

  localparam logic [NTHR_W-1:0]  NTHR_RESET  = 7'd64;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 31'd131072;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ACC,
    S_RD,
    S_RD_TAIL
  } state_t;

  typedef struct packed {
    logic init;
    logic div_start;
    logic acc_issue;
    logic rd_issue;
    logic rd_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_ok;
    logic div_done;
    logic idx_last;
  } status_t;

endpackage

/* hw/rtl/tscc_if.sv */
// Input and result channel interfaces
interface tscc_in_if;
  logic                                valid;
  logic                                ready;
  logic [tscc_pkg::MODE_W-1:0]         mode;
  logic signed [tscc_pkg::SCORE_W-1:0] score;
  logic                                true_positive;

  modport source (output valid, output mode, output score, output true_positive, input ready);
  modport sink   (input valid, input mode, input score, input true_positive, output ready);
endinterface

interface tscc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tscc_pkg::ROW_W-1:0]            row_index;
  logic signed [tscc_pkg::SCORE_W-1:0]   shift;
  logic [tscc_pkg::OUT_CNT_W-1:0]        true_pos_count;
  logic [tscc_pkg::OUT_CNT_W-1:0]        true_neg_count;
  logic [tscc_pkg::OUT_CNT_W-1:0]        false_pos_count;
  logic [tscc_pkg::OUT_CNT_W-1:0]        false_neg_count;
  logic                                  last_row;

  modport source (output valid, output row_index, output shift, output true_pos_count,
                  output true_neg_count, output false_pos_count, output false_neg_count,
                  output last_row, input ready);
  modport sink   (input valid, input row_index, input shift, input true_pos_count,
                  input true_neg_count, input false_pos_count, input false_neg_count,
                  input last_row, output ready);
endinterface

/* hw/rtl/tscc_ram.sv */
// Generic single-write, single-read RAM with registered read data
module tscc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/tscc_ctrl.sv */
// Controller: sequences divide, accumulate sweep, readout and clear
`include "assert_macros.svh"

module tscc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [tscc_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  input  logic                        out_ready,
  output logic                        out_valid,
  output tscc_pkg::cmd_t              cmd,
  input  tscc_pkg::status_t           sts
);

  tscc_pkg::state_t state_r, state_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rd_sel_r, rd_sel_nxt;
  logic             load, issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tscc_pkg::S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      rd_sel_r    <= rd_sel_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_sel_nxt = rd_sel_r;
    cmd        = '0;
    in_ready   = 1'b0;
    load       = 1'b0;
    issue      = 1'b0;
    case (state_r)
      tscc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            tscc_pkg::MODE_ACC: begin
              cmd.init   = 1'b1;
              rd_sel_nxt = 1'b0;
              if (sts.div_ok) begin
                state_nxt = tscc_pkg::S_ACC;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt     = tscc_pkg::S_DIV;
              end
            end
            tscc_pkg::MODE_READ: begin
              cmd.init   = 1'b1;
              rd_sel_nxt = 1'b1;
              if (sts.div_ok) begin
                state_nxt = tscc_pkg::S_RD;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt     = tscc_pkg::S_DIV;
              end
            end
            tscc_pkg::MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
              // unused mode: drop the transfer
            end
          endcase
        end
      end
      tscc_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_nxt = rd_sel_r ? tscc_pkg::S_RD : tscc_pkg::S_ACC;
        end
      end
      tscc_pkg::S_ACC: begin
        cmd.acc_issue = 1'b1;
        if (sts.idx_last) begin
          state_nxt = tscc_pkg::S_IDLE;
        end
      end
      tscc_pkg::S_RD: begin
        load  = pend_r && (!out_valid_r || out_ready);
        issue = !pend_r || load;
        if (issue && sts.idx_last) begin
          state_nxt = tscc_pkg::S_RD_TAIL;
        end
      end
      tscc_pkg::S_RD_TAIL: begin
        load = pend_r && (!out_valid_r || out_ready);
        if (load) begin
          state_nxt = tscc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tscc_pkg::S_IDLE;
      end
    endcase
    cmd.rd_issue = issue;
    cmd.rd_load  = load;
  end

  // row pending in the RAM read register, and the output register's occupancy
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (issue) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  `TSCC_ASSERT(a_tail_has_row, clk, rst_n, (state_r == tscc_pkg::S_RD_TAIL) |-> pend_r,
    "readout tail entered without a pending row")
  `TSCC_ASSERT(a_one_cmd, clk, rst_n,
    $onehot0({cmd.init, cmd.acc_issue, cmd.rd_issue, cmd.clear}),
    "conflicting datapath commands")
  `TSCC_ASSERT(a_load_shows, clk, rst_n, cmd.rd_load |=> out_valid_r,
    "loaded row not presented")

endmodule

/* hw/rtl/tscc_dp.sv */
// Datapath: configuration, shift divider, threshold stepping and counter RAM
`include "assert_macros.svh"

module tscc_dp #(
  parameter int MAX_THRESHOLDS = 64,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tscc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tscc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic signed [tscc_pkg::SCORE_W-1:0]   in_score,
  input  logic                                  in_true_positive,
  input  tscc_pkg::cmd_t                        cmd,
  output tscc_pkg::status_t                     sts,
  output logic [tscc_pkg::ROW_W-1:0]            out_row_index,
  output logic signed [tscc_pkg::SCORE_W-1:0]   out_shift,
  output logic [tscc_pkg::OUT_CNT_W-1:0]        out_true_pos_count,
  output logic [tscc_pkg::OUT_CNT_W-1:0]        out_true_neg_count,
  output logic [tscc_pkg::OUT_CNT_W-1:0]        out_false_pos_count,
  output logic [tscc_pkg::OUT_CNT_W-1:0]        out_false_neg_count,
  output logic                                  out_last_row
);

  localparam int IW     = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
  localparam int NW     = $clog2(MAX_THRESHOLDS + 1);
  localparam int CW     = COUNT_WIDTH;
  localparam int RW     = 4 * CW;
  localparam int TP_LSB = 3 * CW;
  localparam int TN_LSB = 2 * CW;
  localparam int FP_LSB = CW;
  localparam int FN_LSB = 0;
  localparam int QW     = tscc_pkg::RANGE_W;
  localparam int SW     = tscc_pkg::SCORE_W;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // configuration
  logic [tscc_pkg::NTHR_W-1:0]  nthr_r;
  logic [tscc_pkg::RANGE_W-1:0] range_r;
  logic [NW-1:0]                n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nthr_r  <= tscc_pkg::NTHR_RESET;
      range_r <= tscc_pkg::RANGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tscc_pkg::CFG_NUM_THRESHOLDS: nthr_r  <= cfg_wdata[tscc_pkg::NTHR_W-1:0];
        tscc_pkg::CFG_SWEEP_RANGE:    range_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (nthr_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(nthr_r) > 32'(MAX_THRESHOLDS)) begin
      n_eff = NW'(MAX_THRESHOLDS);
    end else begin
      n_eff = NW'(nthr_r);
    end
  end

  // restoring divider: range / n, one quotient bit per cycle
  logic          div_ok_r, div_ok_nxt;
  logic          dbusy_r, dbusy_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW:0]   trial;
  logic          trial_ge;

  assign trial    = {rem_r, range_r[dcnt_r]};
  assign trial_ge = trial >= {1'b0, n_eff};

  always_comb begin
    div_ok_nxt = div_ok_r;
    dbusy_nxt  = dbusy_r;
    dcnt_nxt   = dcnt_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    if (cmd.div_start) begin
      dbusy_nxt = 1'b1;
      dcnt_nxt  = 5'(QW - 1);
      quo_nxt   = '0;
      rem_nxt   = '0;
    end else if (dbusy_r) begin
      quo_nxt = {quo_r[QW-2:0], trial_ge};
      rem_nxt = trial_ge ? NW'(trial - {1'b0, n_eff}) : NW'(trial);
      dcnt_nxt = dcnt_r - 1'b1;
      if (dcnt_r == '0) begin
        dbusy_nxt  = 1'b0;
        div_ok_nxt = 1'b1;
      end
    end
    // a new setting invalidates the cached quotient
    if (cfg_we) begin
      div_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_ok_r <= 1'b0;
      dbusy_r  <= 1'b0;
    end else begin
      div_ok_r <= div_ok_nxt;
      dbusy_r  <= dbusy_nxt;
    end
    dcnt_r <= dcnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  // threshold stepping: q tracks floor(i * range / n), r its remainder
  logic [IW-1:0]        idx_r;
  logic [QW-1:0]        q_r;
  logic [NW-1:0]        r_r;
  logic [NW:0]          rsum;
  logic                 rwrap;
  logic signed [SW-1:0] score_r;
  logic                 tpos_r;
  logic signed [SW-1:0] shift_cur;
  logic signed [SW:0]   sum_cur;
  logic                 pred_cur;
  logic                 advance;
  logic                 idx_last;

  assign advance   = cmd.acc_issue || cmd.rd_issue;
  assign rsum      = {1'b0, r_r} + {1'b0, rem_r};
  assign rwrap     = rsum >= {1'b0, n_eff};
  assign shift_cur = $signed({1'b0, q_r}) - $signed({2'b0, range_r[QW-1:1]});
  assign sum_cur   = {score_r[SW-1], score_r} + {shift_cur[SW-1], shift_cur};
  assign pred_cur  = !sum_cur[SW] && (sum_cur != '0);
  assign idx_last  = NW'(idx_r) == (n_eff - NW'(1));

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      idx_r   <= '0;
      q_r     <= '0;
      r_r     <= '0;
      score_r <= in_score;
      tpos_r  <= in_true_positive;
    end else if (advance) begin
      idx_r <= idx_r + 1'b1;
      q_r   <= q_r + quo_r + QW'(rwrap);
      r_r   <= rwrap ? NW'(rsum - {1'b0, n_eff}) : NW'(rsum);
    end
  end

  // counter RAM, one row of four counters per threshold
  logic [MAX_THRESHOLDS-1:0] vld_r;
  logic [RW-1:0]             rdata;
  logic [RW-1:0]             wdata;
  logic                      wb_v_r;
  logic [IW-1:0]             wb_idx_r;
  logic                      wb_pred_r;
  logic                      wb_vld_r;
  logic [RW-1:0]             wb_row;
  logic [CW-1:0]             tp_n, tn_n, fp_n, fn_n;

  tscc_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_THRESHOLDS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (wb_v_r),
    .waddr (wb_idx_r),
    .wdata (wdata),
    .re    (advance),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else begin
      wb_v_r <= cmd.acc_issue;
    end
    if (cmd.acc_issue) begin
      wb_idx_r  <= idx_r;
      wb_pred_r <= pred_cur;
      wb_vld_r  <= vld_r[idx_r];
    end
  end

  // a clear wins over a write-back landing in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clear) begin
      vld_r <= '0;
    end else if (wb_v_r) begin
      vld_r[wb_idx_r] <= 1'b1;
    end
  end

  always_comb begin
    wb_row = wb_vld_r ? rdata : '0;
    tp_n   = wb_row[TP_LSB +: CW];
    tn_n   = wb_row[TN_LSB +: CW];
    fp_n   = wb_row[FP_LSB +: CW];
    fn_n   = wb_row[FN_LSB +: CW];
    case ({tpos_r, wb_pred_r})
      2'b11:   tp_n = bump(tp_n);
      2'b00:   tn_n = bump(tn_n);
      2'b01:   fp_n = bump(fp_n);
      default: fn_n = bump(fn_n);
    endcase
    wdata = {tp_n, tn_n, fp_n, fn_n};
  end

  // readout: row attributes follow the RAM read, then load into the output register
  logic [IW-1:0]        pend_idx_r;
  logic signed [SW-1:0] pend_shift_r;
  logic                 pend_last_r;
  logic                 pend_vld_r;
  logic [RW-1:0]        rd_row;
  logic [31:0]          idx_ext;
  logic [63:0]          tp_ext, tn_ext, fp_ext, fn_ext;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      pend_idx_r   <= idx_r;
      pend_shift_r <= shift_cur;
      pend_last_r  <= idx_last;
      pend_vld_r   <= vld_r[idx_r];
    end
  end

  always_comb begin
    rd_row  = pend_vld_r ? rdata : '0;
    idx_ext = 32'(pend_idx_r);
    tp_ext  = 64'(rd_row[TP_LSB +: CW]);
    tn_ext  = 64'(rd_row[TN_LSB +: CW]);
    fp_ext  = 64'(rd_row[FP_LSB +: CW]);
    fn_ext  = 64'(rd_row[FN_LSB +: CW]);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      out_row_index       <= idx_ext[tscc_pkg::ROW_W-1:0];
      out_shift           <= pend_shift_r;
      out_true_pos_count  <= tp_ext[tscc_pkg::OUT_CNT_W-1:0];
      out_true_neg_count  <= tn_ext[tscc_pkg::OUT_CNT_W-1:0];
      out_false_pos_count <= fp_ext[tscc_pkg::OUT_CNT_W-1:0];
      out_false_neg_count <= fn_ext[tscc_pkg::OUT_CNT_W-1:0];
      out_last_row        <= pend_last_r;
    end
  end

  always_comb begin
    sts          = '0;
    sts.div_ok   = div_ok_r;
    sts.div_done = dbusy_r && (dcnt_r == '0);
    sts.idx_last = idx_last;
  end

  `TSCC_ASSERT(a_idx_in_range, clk, rst_n, advance |-> (NW'(idx_r) < n_eff),
    "threshold index beyond active count")
  `TSCC_ASSERT(a_div_rem, clk, rst_n, div_ok_r |-> (rem_r < n_eff),
    "cached remainder not below threshold count")
  `TSCC_ASSERT_NEVER(a_div_restart, clk, rst_n, cmd.div_start && dbusy_r,
    "divider restarted while busy")

endmodule

/* hw/rtl/threshold_sweep_confusion_counter_core.sv */
// Top level of the threshold sweep confusion counter
// Per-threshold confusion counting over a swept decision shift. An accumulate
// item takes the transfer, then one counter-RAM read-modify-write per
// threshold, pipelined one row a cycle; a readout moves one row a cycle
// through the RAM read register unless the result channel stalls; a clear
// acts when its transfer is taken. After a write to either register the
// next accumulate or readout first runs the bit-serial divider that forms
// sweep_range / N for the shift stepping. Counters are zero after reset
// with no clearing pass; the last row of a readout may still wait in the
// output register while the next item is taken.
module threshold_sweep_confusion_counter_core #(
  parameter int MAX_THRESHOLDS = 64,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tscc_in_if.sink                         in_if,
  tscc_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [tscc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tscc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tscc_pkg::cmd_t    cmd;
  tscc_pkg::status_t sts;

  tscc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_mode   (in_if.mode),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  tscc_dp #(
    .MAX_THRESHOLDS (MAX_THRESHOLDS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_score            (in_if.score),
    .in_true_positive    (in_if.true_positive),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_row_index       (out_if.row_index),
    .out_shift           (out_if.shift),
    .out_true_pos_count  (out_if.true_pos_count),
    .out_true_neg_count  (out_if.true_neg_count),
    .out_false_pos_count (out_if.false_pos_count),
    .out_false_neg_count (out_if.false_neg_count),
    .out_last_row        (out_if.last_row)
  );

endmodule
